/* rtl/cadence_power_tick_converter_core_macros.svh */
// Assertion macros shared by the cadence and power tick converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CADENCE_POWER_TICK_CONVERTER_CORE_MACROS_SVH
`define CADENCE_POWER_TICK_CONVERTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on an explicit clock and synchronous reset.
`define CPTC_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Concurrent check on the module clock clk and reset rst.
`define CPTC_ASSERT(lbl, prop, msg) \
  `CPTC_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define CPTC_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)
`define CPTC_ASSERT(lbl, prop, msg)
`endif

`endif

/* rtl/cptc_pkg.sv */
// Package for the cadence and power tick converter: widths, constants and pipeline types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cptc_pkg;

  // Input and output field widths.
  localparam int RpmW    = 8;
  localparam int WattsW  = 16;
  localparam int TicksW  = 16;
  localparam int InDataW = 24;
  localparam int OutDataW = 56;

  // Conversion constants.
  localparam logic [16:0] PERIOD_NUM   = 17'd122880;
  localparam logic [15:0] EVENT_NUM    = 16'd61440;
  localparam logic [18:0] TORQUE_NUM   = 19'd305577;
  localparam logic [9:0]  TORQUE_SCALE = 10'd1000;
  localparam logic [8:0]  TORQUE_HALF  = 9'(TORQUE_SCALE / 2);

  // Divider geometry: every lane divides a 35-bit dividend by an 18-bit divisor
  // and produces a 25-bit quotient, five quotient bits per pipeline stage.
  localparam int DividendW  = 35;
  localparam int DenW       = 18;
  localparam int QuotW      = 25;
  localparam int StepsPerStg = 5;
  localparam int NumStages  = QuotW / StepsPerStg;
  localparam int NumLanes   = 3;

  // Lane assignment.
  localparam logic [1:0] LANE_PERIOD = 2'd0;
  localparam logic [1:0] LANE_EVENT  = 2'd1;
  localparam logic [1:0] LANE_TORQUE = 2'd2;

  // One long-division lane: partial remainder, dividend bits still to shift in
  // (quotient bits fill in from the bottom), and the divisor.
  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [QuotW-1:0] work;
    logic [DenW-1:0]  den;
  } lane_t;

  // Contents of one pipeline register.
  typedef struct packed {
    logic                      valid;
    logic                      zero;
    lane_t [NumLanes-1:0]      lane;
  } pipe_t;

endpackage

/* rtl/cadence_power_tick_converter_core.sv */
// A request passes the prep register and the five divider registers; the last is the output register.
// Throughput: one request per cycle while the output is not stalled; the prep stage and five
// divider stages each take one item and advance together, five quotient bits per divider stage.
// A stalled output holds the whole pipeline; a new request is taken whenever the output
// register is empty or being drained. Reset is synchronous and clears all valid bits.
`timescale 1ns / 1ps
`include "cadence_power_tick_converter_core_macros.svh"

module cadence_power_tick_converter_core
  import cptc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] rpm, [23:8] watts
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] period_ticks, [16] period_wrapped, [32:17] event_ticks,
  // [48:33] torque_ticks, [49] torque_wrapped, [55:50] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  pipe_t              stg [0:NumStages];
  logic               en;
  logic [QuotW-1:0]   period_q;
  logic [QuotW-1:0]   event_q;
  logic [QuotW-1:0]   torque_q;
  logic [TicksW-1:0]  period_ticks;
  logic [TicksW-1:0]  event_ticks;
  logic [TicksW-1:0]  torque_ticks;
  logic               period_wrapped;
  logic               torque_wrapped;

  // The pipeline moves whenever the output register is free or drained.
  assign en            = !stg[NumStages].valid || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage.
  cptc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .rpm      (s_axis_tdata[RpmW-1:0]),
    .watts    (s_axis_tdata[RpmW+WattsW-1:RpmW]),
    .pipe_q   (stg[0])
  );

  // Divider stages; the last one is the output register.
  for (genvar i = 0; i < NumStages; i++) begin : g_div
    cptc_div_stage u_div (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .pipe_d (stg[i]),
      .pipe_q (stg[i+1])
    );
  end

  // Format the result; a zero rate forces every field to zero.
  always_comb begin
    period_q = stg[NumStages].lane[LANE_PERIOD].work;
    event_q  = stg[NumStages].lane[LANE_EVENT].work;
    torque_q = stg[NumStages].lane[LANE_TORQUE].work;
    if (stg[NumStages].zero) begin
      period_ticks   = '0;
      period_wrapped = 1'b0;
      event_ticks    = '0;
      torque_ticks   = '0;
      torque_wrapped = 1'b0;
    end else begin
      period_ticks   = period_q[TicksW-1:0];
      period_wrapped = |period_q[QuotW-1:TicksW];
      event_ticks    = event_q[TicksW-1:0];
      torque_ticks   = torque_q[TicksW-1:0];
      torque_wrapped = |torque_q[QuotW-1:TicksW];
    end
  end

  assign m_axis_tvalid = stg[NumStages].valid;
  assign m_axis_tdata  = {6'd0, torque_wrapped, torque_ticks, event_ticks,
                          period_wrapped, period_ticks};

  // The event time is at most 61440 ticks and never wraps.
  `CPTC_ASSERT(a_event_no_wrap, (m_axis_tvalid && !stg[NumStages].zero) |-> (event_q <= QuotW'(EVENT_NUM)), "event quotient above its bound")
  // The period only wraps at the lowest rate, rpm 1, and its quotient never exceeds 122880.
  `CPTC_ASSERT(a_period_wrap_range, (m_axis_tvalid && period_wrapped) |-> (period_q <= QuotW'(PERIOD_NUM)), "period quotient above its bound")
  // A zero rate gives an all-zero result word.
  `CPTC_ASSERT(a_zero_rate_clear, (m_axis_tvalid && stg[NumStages].zero) |-> (m_axis_tdata == '0), "zero rate gave a nonzero result")

endmodule

/* rtl/cptc_prep.sv */
// Input stage of the tick converter: forms the three dividends and divisors.
// Depends on cptc_pkg.
`timescale 1ns / 1ps

module cptc_prep
  import cptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RpmW-1:0]   rpm,
  input  logic [WattsW-1:0] watts,
  output pipe_t             pipe_q
);

  logic [DividendW-1:0] torque_num;
  logic [DividendW-1:0] period_num;
  logic [DividendW-1:0] event_num;
  logic [DenW-1:0]      torque_den;
  logic [DenW-1:0]      rate_den;
  pipe_t                pipe_next;

  // Rounded quotient is floor((n + d/2) / d); d/2 of rpm*1000 is rpm*500 exactly.
  // Operands are widened first so the products keep every bit.
  always_comb begin
    torque_num = DividendW'(watts) * DividendW'(TORQUE_NUM)
               + DividendW'(rpm) * DividendW'(TORQUE_HALF);
    torque_den = DenW'(rpm) * DenW'(TORQUE_SCALE);
    rate_den   = DenW'(rpm);
    period_num = DividendW'(PERIOD_NUM) + DividendW'(rpm >> 1);
    event_num  = DividendW'(EVENT_NUM) + DividendW'(rpm >> 1);
  end

  // Seed each lane: the top dividend bits are already below the divisor.
  always_comb begin
    pipe_next.valid = in_valid;
    pipe_next.zero  = (rpm == '0);
    pipe_next.lane[LANE_PERIOD].rem  = DenW'(period_num[DividendW-1:QuotW]);
    pipe_next.lane[LANE_PERIOD].work = period_num[QuotW-1:0];
    pipe_next.lane[LANE_PERIOD].den  = rate_den;
    pipe_next.lane[LANE_EVENT].rem   = DenW'(event_num[DividendW-1:QuotW]);
    pipe_next.lane[LANE_EVENT].work  = event_num[QuotW-1:0];
    pipe_next.lane[LANE_EVENT].den   = rate_den;
    pipe_next.lane[LANE_TORQUE].rem  = DenW'(torque_num[DividendW-1:QuotW]);
    pipe_next.lane[LANE_TORQUE].work = torque_num[QuotW-1:0];
    pipe_next.lane[LANE_TORQUE].den  = torque_den;
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_q.valid <= 1'b0;
    end else if (en) begin
      pipe_q <= pipe_next;
    end
  end

endmodule

/* rtl/cptc_div_stage.sv */
// One divider stage of the tick converter: five restoring-division steps per lane.
// Depends on cptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cadence_power_tick_converter_core_macros.svh"

module cptc_div_stage
  import cptc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  pipe_t pipe_d,
  output pipe_t pipe_q
);

  pipe_t           pipe_next;
  logic [DenW:0]   trial;
  logic            fits;

  // Shift one dividend bit into the remainder, subtract the divisor when it fits.
  always_comb begin
    pipe_next = pipe_d;
    trial     = '0;
    fits      = 1'b0;
    for (int s = 0; s < StepsPerStg; s++) begin
      for (int l = 0; l < NumLanes; l++) begin
        trial = {pipe_next.lane[l].rem, pipe_next.lane[l].work[QuotW-1]};
        fits  = (trial >= {1'b0, pipe_next.lane[l].den});
        pipe_next.lane[l].work = {pipe_next.lane[l].work[QuotW-2:0], fits};
        if (fits) begin
          pipe_next.lane[l].rem = DenW'(trial - {1'b0, pipe_next.lane[l].den});
        end else begin
          pipe_next.lane[l].rem = trial[DenW-1:0];
        end
      end
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_q.valid <= 1'b0;
    end else if (en) begin
      pipe_q <= pipe_next;
    end
  end

  // The partial remainder stays below the divisor for every nonzero rate.
  `CPTC_ASSERT(a_rem_below_den, (pipe_q.valid && !pipe_q.zero) |-> ((pipe_q.lane[0].rem < pipe_q.lane[0].den) && (pipe_q.lane[1].rem < pipe_q.lane[1].den) && (pipe_q.lane[2].rem < pipe_q.lane[2].den)), "divider remainder not below divisor")
  // A stalled stage keeps its contents.
  `CPTC_ASSERT(a_stall_holds, (!en && pipe_q.valid) |=> $stable(pipe_q), "stage changed while stalled")
  // Both rate lanes always divide by the same rpm.
  `CPTC_ASSERT(a_rate_den_match, pipe_q.valid |-> (pipe_q.lane[0].den == pipe_q.lane[1].den), "period and event divisors differ")

endmodule
